// ===== rtl/drc_pkg.sv =====
package drc_pkg;

	localparam int MAX_RECTS_DEF = 64;
	localparam int COORD_W       = 18;
	localparam int CANVAS_W      = 15;
	localparam int CFG_IDX_W     = 2;
	localparam int COUNT_OUT_W   = 7;

	localparam logic [CANVAS_W-1:0] CANVAS_WIDTH_RST  = 15'd1024;
	localparam logic [CANVAS_W-1:0] CANVAS_HEIGHT_RST = 15'd768;

	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] h;
	} box_t;

endpackage

// ===== rtl/drc_ram.sv =====
module drc_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/dirty_rect_coalescer.sv =====
// Damage-rectangle list with merge on add and clipped flush.
//
// Input channel (in_valid / in_stall): action 0 adds rect_x/y/w/h, action 1
// flushes. A word is taken when in_valid is high and in_stall low; in_stall
// stays high while an item is being worked on, so one item is in flight.
// Output channel (out_valid / out_stall): an add gives one word with
// rect_valid 0, last 1 and the new pending_count. A flush gives one word per
// stored rectangle that survives clipping to the canvas, the final one marked
// by last; if none survive, one empty word with last 1.
// Configuration (cfg_valid / cfg_ready): index 0 canvas width, index 1 canvas
// height; cfg_ready is always high, other indexes are dropped.
// An add scans the stored entries in turn; on a merge it absorbs the entry,
// moves the last entry into its slot and restarts the scan from entry 0. If
// the list is full, it collapses with the new rectangle into one bounding
// rectangle. A flush reads each stored entry in turn. The scan loop follows
// from the single read port of the rectangle stores.
// Reset clears the list count and loads the default canvas 1024 x 768; the
// stores themselves are not cleared. A stalled receiver holds the output word;
// no new word is sent until it is taken, but a flush still skips clipped entries.
module dirty_rect_coalescer
	import drc_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic signed [15:0]          rect_x,
	input  logic signed [15:0]          rect_y,
	input  logic signed [15:0]          rect_w,
	input  logic signed [15:0]          rect_h,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        rect_valid,
	output logic [CANVAS_W-1:0]         out_x,
	output logic [CANVAS_W-1:0]         out_y,
	output logic [CANVAS_W-1:0]         out_w,
	output logic [CANVAS_W-1:0]         out_h,
	output logic                        last,
	output logic [COUNT_OUT_W-1:0]      pending_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CANVAS_W-1:0]         cfg_data
);

	localparam int AW = $clog2(MAX_RECTS);
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int SW = COORD_W + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CHK, S_MRD, S_MWR, S_APP, S_CRD, S_CCHK, S_RES,
		S_FRD, S_FCHK, S_FEND
	} state_t;

	typedef struct packed {
		logic                vis;
		logic [CANVAS_W-1:0] x;
		logic [CANVAS_W-1:0] y;
		logic [CANVAS_W-1:0] w;
		logic [CANVAS_W-1:0] h;
	} clip_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	box_t                nb_q;
	clip_t               hold_q;
	logic                have_q;
	logic [CANVAS_W-1:0] cw_q;
	logic [CANVAS_W-1:0] ch_q;

	logic                out_valid_q;
	logic                rect_valid_q;
	logic [CANVAS_W-1:0] out_x_q, out_y_q, out_w_q, out_h_q;
	logic                last_q;
	logic [COUNT_OUT_W-1:0] pend_q;

	logic                  o_wr_en;
	logic [AW-1:0]         o_wr_addr, o_rd_addr;
	logic [2*COORD_W-1:0]  o_rd_data, e_rd_data;
	logic                  o_rd_en;
	box_t                  wr_box, rd_box, join_box;
	logic                  meet;
	clip_t                 clip;
	logic                  out_free;
	logic                  idx_lt;

	assign rd_box = '{x: o_rd_data[2*COORD_W-1:COORD_W], y: o_rd_data[COORD_W-1:0],
	                  w: e_rd_data[2*COORD_W-1:COORD_W], h: e_rd_data[COORD_W-1:0]};

	drc_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_RECTS)) u_origin (
		.clk(clk), .wr_en(o_wr_en), .wr_addr(o_wr_addr),
		.wr_data({wr_box.x, wr_box.y}),
		.rd_en(o_rd_en), .rd_addr(o_rd_addr), .rd_data(o_rd_data)
	);

	drc_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_RECTS)) u_extent (
		.clk(clk), .wr_en(o_wr_en), .wr_addr(o_wr_addr),
		.wr_data({wr_box.w, wr_box.h}),
		.rd_en(o_rd_en), .rd_addr(o_rd_addr), .rd_data(e_rd_data)
	);

	assign idx_lt    = (idx_q < count_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// Touch-or-overlap test and bounding union of the held rectangle and the read entry
	always_comb begin
		logic signed [SW-1:0] ar, br, ab, bb, rt, bt, jx, jy;
		ar = SW'(nb_q.x) + SW'(nb_q.w);
		br = SW'(rd_box.x) + SW'(rd_box.w);
		ab = SW'(nb_q.y) + SW'(nb_q.h);
		bb = SW'(rd_box.y) + SW'(rd_box.h);
		meet = (SW'(nb_q.x) <= br) && (SW'(rd_box.x) <= ar) &&
		       (SW'(nb_q.y) <= bb) && (SW'(rd_box.y) <= ab);
		rt = (ar > br) ? ar : br;
		bt = (ab > bb) ? ab : bb;
		jx = (nb_q.x < rd_box.x) ? SW'(nb_q.x) : SW'(rd_box.x);
		jy = (nb_q.y < rd_box.y) ? SW'(nb_q.y) : SW'(rd_box.y);
		join_box.x = jx[COORD_W-1:0];
		join_box.y = jy[COORD_W-1:0];
		join_box.w = COORD_W'(rt - jx);
		join_box.h = COORD_W'(bt - jy);
	end

	// Clip the read entry to the canvas
	always_comb begin
		logic signed [SW-1:0] l, t, r, b, cwx, chx, dw, dh;
		cwx = SW'({1'b0, cw_q});
		chx = SW'({1'b0, ch_q});
		l = (rd_box.x < 0) ? '0 : SW'(rd_box.x);
		t = (rd_box.y < 0) ? '0 : SW'(rd_box.y);
		r = SW'(rd_box.x) + SW'(rd_box.w);
		b = SW'(rd_box.y) + SW'(rd_box.h);
		if (r > cwx) r = cwx;
		if (b > chx) b = chx;
		dw = r - l;
		dh = b - t;
		clip.vis = (r > l) && (b > t);
		clip.x = l[CANVAS_W-1:0];
		clip.y = t[CANVAS_W-1:0];
		clip.w = dw[CANVAS_W-1:0];
		clip.h = dh[CANVAS_W-1:0];
	end

	// Store access per state
	always_comb begin
		o_rd_en   = 1'b0;
		o_rd_addr = idx_q[AW-1:0];
		o_wr_en   = 1'b0;
		o_wr_addr = idx_q[AW-1:0];
		wr_box    = nb_q;
		case (state_q)
			S_RD, S_FRD: o_rd_en = idx_lt;
			S_CRD: begin
				o_rd_en = idx_lt;
				if (!idx_lt) begin
					o_wr_en   = 1'b1;
					o_wr_addr = '0;
				end
			end
			S_MRD: begin
				o_rd_en   = 1'b1;
				o_rd_addr = count_q[AW-1:0];
			end
			S_MWR: begin
				o_wr_en = 1'b1;
				wr_box  = rd_box;
			end
			S_APP: begin
				o_wr_en   = (count_q < CW'(MAX_RECTS));
				o_wr_addr = count_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			have_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cw_q        <= CANVAS_WIDTH_RST;
			ch_q        <= CANVAS_HEIGHT_RST;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CANVAS_WIDTH:  cw_q <= cfg_data;
					REG_CANVAS_HEIGHT: ch_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q  <= '0;
						have_q <= 1'b0;
						nb_q   <= '{x: COORD_W'(rect_x), y: COORD_W'(rect_y),
						            w: COORD_W'(rect_w), h: COORD_W'(rect_h)};
						if (action == ACT_FLUSH) begin
							state_q <= S_FRD;
						end else if (rect_w > 0 && rect_h > 0) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_RD: state_q <= idx_lt ? S_CHK : S_APP;
				S_CHK: begin
					if (meet) begin
						// absorb the entry, pull the tail into its slot, restart
						nb_q    <= join_box;
						count_q <= count_q - 1'b1;
						state_q <= S_MRD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: begin
					idx_q   <= '0;
					state_q <= S_RD;
				end
				S_APP: begin
					if (count_q < CW'(MAX_RECTS)) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RES;
					end else begin
						idx_q   <= '0;
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					if (idx_lt) begin
						state_q <= S_CCHK;
					end else begin
						count_q <= CW'(1);
						state_q <= S_RES;
					end
				end
				S_CCHK: begin
					nb_q    <= join_box;
					idx_q   <= idx_q + 1'b1;
					state_q <= S_CRD;
				end
				S_RES: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						rect_valid_q <= 1'b0;
						out_x_q      <= '0;
						out_y_q      <= '0;
						out_w_q      <= '0;
						out_h_q      <= '0;
						last_q       <= 1'b1;
						pend_q       <= COUNT_OUT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				S_FRD: state_q <= idx_lt ? S_FCHK : S_FEND;
				S_FCHK: begin
					// hold one survivor back so the final one can carry last
					if (!clip.vis) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FRD;
					end else if (!have_q || out_free) begin
						if (have_q) begin
							out_valid_q  <= 1'b1;
							rect_valid_q <= 1'b1;
							out_x_q      <= hold_q.x;
							out_y_q      <= hold_q.y;
							out_w_q      <= hold_q.w;
							out_h_q      <= hold_q.h;
							last_q       <= 1'b0;
							pend_q       <= '0;
						end
						hold_q  <= clip;
						have_q  <= 1'b1;
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_FEND: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						rect_valid_q <= have_q;
						out_x_q      <= have_q ? hold_q.x : '0;
						out_y_q      <= have_q ? hold_q.y : '0;
						out_w_q      <= have_q ? hold_q.w : '0;
						out_h_q      <= have_q ? hold_q.h : '0;
						last_q       <= 1'b1;
						pend_q       <= '0;
						count_q      <= '0;
						have_q       <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign rect_valid    = rect_valid_q;
	assign out_x         = out_x_q;
	assign out_y         = out_y_q;
	assign out_w         = out_w_q;
	assign out_h         = out_h_q;
	assign last          = last_q;
	assign pending_count = pend_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECTS))
		else $error("list count beyond capacity");

	a_flush_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rect_valid |-> pending_count == '0)
		else $error("flush word with non-zero pending count");

	a_move_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MWR |-> idx_q <= count_q)
		else $error("tail move outside the list");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FEND && out_free |=> count_q == '0)
		else $error("flush left entries behind");

endmodule
